@@ src/sha256_pkg.sv @@
// Package for the SHA-256 byte hasher: controller states, command/status structs,
// round constants and initial hash values. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sha256_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_COMP,
    ST_FOLD,
    ST_EMIT
  } ctrl_state_t;

  typedef enum logic [1:0] {
    SRC_DATA,
    SRC_PAD80,
    SRC_ZERO,
    SRC_LEN
  } byte_src_t;

  typedef struct packed {
    logic      put_byte;
    byte_src_t src;
    logic      add_bits;
    logic      comp_start;
    logic      comp_round;
    logic      fold;
    logic      emit_load;
    logic      reinit;
  } sha_cmd_t;

  typedef struct packed {
    logic [5:0] fill;
    logic       last_round;
    logic [2:0] emit_idx;
  } sha_stat_t;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_OFFSET = 6'd56;

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
    rotr = (v >> n) | (v << (32 - n));
  endfunction

endpackage
`default_nettype wire

@@ src/sha256_ctrl.sv @@
// Controller for the SHA-256 byte hasher: sequences absorb, padding,
// compression rounds, hash fold and digest emission. Uses sha256_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sha256_ctrl (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  input  wire                   in_operation,
  output logic                  in_stall,
  output logic                  out_valid,
  input  wire                   out_stall,
  input  sha256_pkg::sha_stat_t stat,
  output sha256_pkg::sha_cmd_t  cmd
);
  import sha256_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        fin_r, fin_nxt;   // compression belongs to the finish sequence
  logic        accept;
  // tracks whether the length bytes already went into the compressed block
  logic        len_done_r, len_done_nxt;
  // length bytes may go into the current padding block
  logic        len_arm_r, len_arm_nxt;

  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fin_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fin_r   <= fin_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    fin_nxt   = fin_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_operation) begin
            // pad byte closing a full block compresses right away
            state_nxt = (stat.fill == 6'd63) ? ST_COMP : ST_PAD;
            fin_nxt   = 1'b1;
          end else if (stat.fill == 6'd63) begin
            state_nxt = ST_COMP;
            fin_nxt   = 1'b0;
          end
        end
      end
      ST_PAD: begin
        if (stat.fill == 6'd63) state_nxt = ST_COMP;
      end
      ST_COMP: begin
        if (stat.last_round) state_nxt = ST_FOLD;
      end
      ST_FOLD: begin
        // fill is zero here; a finish that has not reached the length yet pads on
        if (!fin_r) state_nxt = ST_IDLE;
        else if (len_done_r) state_nxt = ST_EMIT;
        else state_nxt = ST_PAD;
      end
      ST_EMIT: begin
        if (!out_stall && stat.emit_idx == 3'd7) begin
          state_nxt = ST_IDLE;
          fin_nxt   = 1'b0;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_done_r <= 1'b0;
      len_arm_r  <= 1'b0;
    end else begin
      len_done_r <= len_done_nxt;
      len_arm_r  <= len_arm_nxt;
    end
  end

  always_comb begin
    cmd          = '0;
    cmd.src      = SRC_DATA;
    in_stall     = 1'b1;
    out_valid    = 1'b0;
    len_done_nxt = len_done_r;
    len_arm_nxt  = len_arm_r;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        len_done_nxt = 1'b0;
        // room for the length only if the pad byte lands before offset 56
        len_arm_nxt  = (stat.fill < LEN_OFFSET);
        if (in_valid) begin
          if (in_operation) begin
            cmd.put_byte = 1'b1;
            cmd.src      = SRC_PAD80;
          end else begin
            cmd.put_byte = 1'b1;
            cmd.src      = SRC_DATA;
            cmd.add_bits = 1'b1;
          end
          cmd.comp_start = !in_operation && stat.fill == 6'd63;
          if (in_operation && stat.fill == 6'd63) cmd.comp_start = 1'b1;
        end
      end
      ST_PAD: begin
        cmd.put_byte = 1'b1;
        cmd.src      = (len_arm_r && stat.fill >= LEN_OFFSET) ? SRC_LEN : SRC_ZERO;
        if (stat.fill == 6'd63) begin
          cmd.comp_start = 1'b1;
          if (len_arm_r) len_done_nxt = 1'b1;
        end
      end
      ST_COMP: cmd.comp_round = 1'b1;
      ST_FOLD: begin
        cmd.fold = 1'b1;
        if (fin_r && len_done_r) cmd.emit_load = 1'b1;
        if (fin_r && !len_done_r) len_arm_nxt = 1'b1;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (!out_stall && stat.emit_idx == 3'd7) cmd.reinit = 1'b1;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

@@ src/sha256_dp.sv @@
// Datapath for the SHA-256 byte hasher: block buffer, message schedule window,
// round unit, hash words, bit counter and digest word index. Uses sha256_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sha256_dp (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire  [7:0]            in_data_byte,
  input  wire                   out_stall,
  input  sha256_pkg::sha_cmd_t  cmd,
  output sha256_pkg::sha_stat_t stat,
  output logic [31:0]           out_digest_word,
  output logic [2:0]            out_word_index,
  output logic                  out_last_word
);
  import sha256_pkg::*;

  logic [31:0] hash_r  [8];
  logic [31:0] blk_r   [16];
  logic [31:0] w_r     [16];   // sliding schedule window, w_r[0] is the current word
  logic [31:0] s_r     [8];
  logic [5:0]  fill_r;
  logic [5:0]  round_r;
  logic [63:0] bits_r;
  logic [2:0]  idx_r;
  logic        stat_emit_adv;
  logic        emit_r;

  logic [7:0]  byte_in;
  logic [2:0]  len_sel;
  logic [31:0] w_new, sg0, sg1, big0, big1, ch, maj, t1, t2;

  assign len_sel = fill_r[2:0];

  always_comb begin
    unique case (cmd.src)
      SRC_DATA:  byte_in = in_data_byte;
      SRC_PAD80: byte_in = PAD_BYTE;
      SRC_ZERO:  byte_in = 8'h00;
      SRC_LEN:   byte_in = bits_r[(7 - len_sel) * 8 +: 8];
      default:   byte_in = 8'h00;
    endcase
  end

  assign sg0   = rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3);
  assign sg1   = rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10);
  assign w_new = sg1 + w_r[9] + sg0 + w_r[0];
  assign big1  = rotr(s_r[4], 6) ^ rotr(s_r[4], 11) ^ rotr(s_r[4], 25);
  assign ch    = (s_r[4] & s_r[5]) ^ (~s_r[4] & s_r[6]);
  assign t1    = s_r[7] + big1 + ch + ROUND_K[round_r] + w_r[0];
  assign big0  = rotr(s_r[0], 2) ^ rotr(s_r[0], 13) ^ rotr(s_r[0], 22);
  assign maj   = (s_r[0] & s_r[1]) ^ (s_r[0] & s_r[2]) ^ (s_r[1] & s_r[2]);
  assign t2    = big0 + maj;

  // block buffer: payload, no reset
  always_ff @(posedge clk) begin
    if (cmd.put_byte)
      blk_r[fill_r[5:2]][(3 - fill_r[1:0]) * 8 +: 8] <= byte_in;
  end

  always_ff @(posedge clk) begin
    if (cmd.comp_start) begin
      for (int i = 0; i < 15; i++) w_r[i] <= blk_r[i];
      // last byte lands this cycle; merge it into word 15
      w_r[15] <= {blk_r[15][31:8], byte_in};
      for (int i = 0; i < 8; i++) s_r[i] <= hash_r[i];
    end else if (cmd.comp_round) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i + 1];
      w_r[15] <= w_new;
      s_r[7] <= s_r[6];
      s_r[6] <= s_r[5];
      s_r[5] <= s_r[4];
      s_r[4] <= s_r[3] + t1;
      s_r[3] <= s_r[2];
      s_r[2] <= s_r[1];
      s_r[1] <= s_r[0];
      s_r[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) hash_r[i] <= INIT_HASH[i];
      fill_r  <= '0;
      round_r <= '0;
      bits_r  <= '0;
      idx_r   <= '0;
    end else begin
      if (cmd.put_byte) fill_r <= fill_r + 6'd1;
      if (cmd.add_bits) bits_r <= bits_r + 64'd8;
      if (cmd.comp_start) round_r <= '0;
      else if (cmd.comp_round) round_r <= round_r + 6'd1;
      if (cmd.fold)
        for (int i = 0; i < 8; i++) hash_r[i] <= hash_r[i] + s_r[i];
      if (cmd.emit_load) idx_r <= '0;
      else if (!out_stall && cmd.reinit == 1'b0 && stat_emit_adv) idx_r <= idx_r + 3'd1;
      if (cmd.reinit) begin
        for (int i = 0; i < 8; i++) hash_r[i] <= INIT_HASH[i];
        fill_r <= '0;
        bits_r <= '0;
        idx_r  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)            emit_r <= 1'b0;
    else if (cmd.emit_load) emit_r <= 1'b1;
    else if (cmd.reinit)    emit_r <= 1'b0;
  end
  assign stat_emit_adv = emit_r;

  assign out_digest_word = hash_r[idx_r];
  assign out_word_index  = idx_r;
  assign out_last_word   = (idx_r == 3'd7);

  assign stat.fill       = fill_r;
  assign stat.last_round = (round_r == 6'd63);
  assign stat.emit_idx   = idx_r;

endmodule
`default_nettype wire

@@ src/sha256_byte_hasher_unit.sv @@
// SHA-256 byte hasher top level: one controller, one datapath. Uses sha256_pkg.
// Absorb: each 64th byte starts compression rounds and a fold, with input stalled.
// Finish: pad, zero and length bytes, one or two compressions, then
// eight digest words, one per cycle while out_stall is low.
// Rate is set by the single shared round unit, one round per cycle.
// Reset (synchronous, rst_n low) loads the initial hash values and clears counters.
`timescale 1ns / 1ps
`default_nettype none
module sha256_byte_hasher_unit (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire         in_operation,
  input  wire  [7:0]  in_data_byte,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);
  import sha256_pkg::*;

  sha_cmd_t  cmd;
  sha_stat_t stat;
  logic      in_stall_c, out_valid_c;

  sha256_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_operation(in_operation),
    .in_stall(in_stall_c), .out_valid(out_valid_c), .out_stall(out_stall),
    .stat(stat), .cmd(cmd)
  );

  sha256_dp u_dp (
    .clk(clk), .rst_n(rst_n), .in_data_byte(in_data_byte), .out_stall(out_stall),
    .cmd(cmd), .stat(stat), .out_digest_word(out_digest_word),
    .out_word_index(out_word_index), .out_last_word(out_last_word)
  );

  assign in_stall  = in_stall_c;
  assign out_valid = out_valid_c;

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input taken during digest run");
  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_word) |-> out_word_index == 3'd7) else $error("last flag");
  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last_word) |=> !out_valid) else $error("run end");

endmodule
`default_nettype wire
